// File: design/bir_pkg.sv
`default_nettype none
package bir_pkg;

  localparam int unsigned MAX_SRC_WIDTH  = 512;
  localparam int unsigned MAX_SRC_HEIGHT = 512;
  localparam int unsigned FRAC_BITS      = 8;

  localparam int unsigned POS_FRAC     = 16;
  localparam int unsigned CLAMP_MARGIN = 66;

  localparam int unsigned XW = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YW = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned AW = XW + YW;

  localparam int unsigned LOAD_X_W = 9;
  localparam int unsigned LOAD_Y_W = 9;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned PIX_W    = 3 * CH_W;
  localparam int unsigned DST_W    = 12;
  localparam int unsigned SIZE_W   = 10;
  localparam int unsigned SCALE_W  = 20;
  localparam int unsigned OUT_W    = 16;

  localparam int unsigned LOAD_X_LSB = 0;
  localparam int unsigned LOAD_Y_LSB = LOAD_X_LSB + LOAD_X_W;
  localparam int unsigned RED_LSB    = LOAD_Y_LSB + LOAD_Y_W;
  localparam int unsigned GREEN_LSB  = RED_LSB + CH_W;
  localparam int unsigned BLUE_LSB   = GREEN_LSB + CH_W;
  localparam int unsigned DST_X_LSB  = BLUE_LSB + CH_W;
  localparam int unsigned DST_Y_LSB  = DST_X_LSB + DST_W;
  localparam int unsigned IN_BITS    = DST_Y_LSB + DST_W;
  localparam int unsigned S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W  = 3 * OUT_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SCALE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 2'd3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(255 << 8);

endpackage
`default_nettype wire

// File: design/bilinear_image_resampler_unit.sv
`default_nettype none
// Bilinear RGB resampler. A load beat (tuser low) writes one source pixel into the
// on-chip frame store in the cycle it is taken; a sample beat (tuser high) maps the
// destination coordinate through the Q16 scale, clamps it inside the source and
// returns the blend of the four neighbours with 8 fraction bits per channel.
// A load does not hold the input; a sample runs through multiply, clamp, weights, four
// reads through the single read port of the frame store, accumulate and hand-over to
// the output register, and the next beat is taken in the cycle after. A result
// waiting on the output does not stop loads or the next sample from starting, but
// that sample then holds in its hand-over cycle, and the input with it, until the
// waiting result is taken.
// The frame store is not cleared: every pixel a sample touches must be loaded first.
module bilinear_image_resampler_unit
  import bir_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // load_x, load_y, in_red, in_green, in_blue, dst_x, dst_y, zero pad
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_red, out_green, out_blue
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PROD_W = DST_W + SCALE_W;
  localparam int unsigned FW     = FRAC_BITS + 1;
  localparam int unsigned WW     = 2 * FRAC_BITS + 1;
  localparam int unsigned ACC_W  = CH_W + WW;
  localparam int unsigned SUM_SH = 2 * FRAC_BITS - 8;
  localparam int unsigned ONE    = 1 << FRAC_BITS;
  localparam int unsigned DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_MAP   = 6'b000100,
    S_WGT   = 6'b001000,
    S_FETCH = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [SIZE_W-1:0]  src_width_q, src_height_q;
  logic [SCALE_W-1:0] scale_x_q, scale_y_q;

  logic [DST_W-1:0]  dst_x_q, dst_y_q;
  logic [PROD_W-1:0] prod_x_q, prod_y_q;
  logic [PROD_W-1:0] px_q, py_q;
  logic [XW-1:0]     x0_q, x1_q;
  logic [YW-1:0]     y0_q, y1_q;
  logic [WW-1:0]     wgt_q [4];
  logic [2:0]        rd_cnt_q;
  logic              tap_vld_q;
  logic [1:0]        tap_idx_q;
  logic [ACC_W-1:0]  acc_q [3];
  logic [ACC_W-1:0]  acc_d [3];
  logic [PIX_W-1:0]  rd_data_q;
  logic              out_vld_q;
  logic [M_TDATA_W-1:0] out_data_q;

  logic [PIX_W-1:0] frame_mem [DEPTH];

  logic s_acc, ld_we, rd_en, out_load;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [PIX_W-1:0] wr_pix;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [PROD_W-1:0] lim_x, lim_y;
  logic [SIZE_W-1:0] x0p1, y0p1;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [FW-1:0] ofx, ofy;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign ld_we         = s_acc & (s_axis_tuser == OP_LOAD);
  assign wr_addr = {s_axis_tdata[LOAD_Y_LSB +: YW], s_axis_tdata[LOAD_X_LSB +: XW]};
  assign wr_pix  = {s_axis_tdata[RED_LSB +: CH_W], s_axis_tdata[GREEN_LSB +: CH_W],
                    s_axis_tdata[BLUE_LSB +: CH_W]};

  // effective sizes
  always_comb begin
    if (src_width_q < SIZE_W'(2)) begin
      w_eff = SIZE_W'(2);
    end else if (src_width_q > SIZE_W'(MAX_SRC_WIDTH)) begin
      w_eff = SIZE_W'(MAX_SRC_WIDTH);
    end else begin
      w_eff = src_width_q;
    end
    if (src_height_q < SIZE_W'(2)) begin
      h_eff = SIZE_W'(2);
    end else if (src_height_q > SIZE_W'(MAX_SRC_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_SRC_HEIGHT);
    end else begin
      h_eff = src_height_q;
    end
  end

  assign lim_x = (PROD_W'(w_eff - SIZE_W'(1)) << POS_FRAC) - PROD_W'(CLAMP_MARGIN);
  assign lim_y = (PROD_W'(h_eff - SIZE_W'(1)) << POS_FRAC) - PROD_W'(CLAMP_MARGIN);

  assign x0p1 = SIZE_W'(px_q[POS_FRAC +: XW]) + SIZE_W'(1);
  assign y0p1 = SIZE_W'(py_q[POS_FRAC +: YW]) + SIZE_W'(1);
  assign fx   = px_q[POS_FRAC - FRAC_BITS +: FRAC_BITS];
  assign fy   = py_q[POS_FRAC - FRAC_BITS +: FRAC_BITS];
  assign ofx  = FW'(ONE) - FW'(fx);
  assign ofy  = FW'(ONE) - FW'(fy);

  assign rd_en = (state_q == S_FETCH) & ~rd_cnt_q[2];

  always_comb begin
    case (rd_cnt_q[1:0])
      2'd0:    rd_addr = {y0_q, x0_q};
      2'd1:    rd_addr = {y0_q, x1_q};
      2'd2:    rd_addr = {y1_q, x0_q};
      default: rd_addr = {y1_q, x1_q};
    endcase
  end

  // multiply-accumulate of one neighbour per cycle
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_d[c] = acc_q[c] + ACC_W'(rd_data_q[CH_W*(2-c) +: CH_W]) * ACC_W'(wgt_q[tap_idx_q]);
    end
  end

  assign out_load = (state_q == S_DONE) & (~out_vld_q | m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc && s_axis_tuser == OP_SAMPLE) state_d = S_MUL;
      end
      S_MUL:   state_d = S_MAP;
      S_MAP:   state_d = S_WGT;
      S_WGT:   state_d = S_FETCH;
      S_FETCH: begin
        if (rd_cnt_q[2]) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      src_width_q  <= SIZE_W'(512);
      src_height_q <= SIZE_W'(512);
      scale_x_q    <= SCALE_W'(65536);
      scale_y_q    <= SCALE_W'(65536);
      rd_cnt_q     <= '0;
      tap_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SIZE_W-1:0];
          REG_SRC_HEIGHT: src_height_q <= cfg_data_i[SIZE_W-1:0];
          REG_SCALE_X:    scale_x_q    <= cfg_data_i;
          REG_SCALE_Y:    scale_y_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_WGT) begin
        rd_cnt_q <= '0;
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + 3'd1;
      end
      tap_vld_q <= rd_en;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      dst_x_q <= s_axis_tdata[DST_X_LSB +: DST_W];
      dst_y_q <= s_axis_tdata[DST_Y_LSB +: DST_W];
    end
    if (state_q == S_MUL) begin
      prod_x_q <= PROD_W'(dst_x_q) * PROD_W'(scale_x_q);
      prod_y_q <= PROD_W'(dst_y_q) * PROD_W'(scale_y_q);
    end
    if (state_q == S_MAP) begin
      px_q <= (prod_x_q > lim_x) ? lim_x : prod_x_q;
      py_q <= (prod_y_q > lim_y) ? lim_y : prod_y_q;
    end
    if (state_q == S_WGT) begin
      x0_q <= px_q[POS_FRAC +: XW];
      y0_q <= py_q[POS_FRAC +: YW];
      x1_q <= (x0p1 < w_eff - SIZE_W'(1)) ? x0p1[XW-1:0] : XW'(w_eff - SIZE_W'(1));
      y1_q <= (y0p1 < h_eff - SIZE_W'(1)) ? y0p1[YW-1:0] : YW'(h_eff - SIZE_W'(1));
      wgt_q[0] <= WW'(ofx) * WW'(ofy);
      wgt_q[1] <= WW'(fx)  * WW'(ofy);
      wgt_q[2] <= WW'(ofx) * WW'(fy);
      wgt_q[3] <= WW'(fx)  * WW'(fy);
      for (int c = 0; c < 3; c++) acc_q[c] <= '0;
    end else if (tap_vld_q) begin
      for (int c = 0; c < 3; c++) acc_q[c] <= acc_d[c];
    end
    tap_idx_q <= rd_cnt_q[1:0];
    if (out_load) begin
      out_data_q <= {acc_q[2][SUM_SH +: OUT_W], acc_q[1][SUM_SH +: OUT_W],
                     acc_q[0][SUM_SH +: OUT_W]};
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (ld_we) frame_mem[wr_addr] <= wr_pix;
    if (rd_en) rd_data_q <= frame_mem[rd_addr];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// File: design/bir_checker.sv
`default_nettype none
module bir_checker
  import bir_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [M_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                  cfg_we_i,
  input wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // the input stays ready after a load
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD |=> s_axis_tready)
    else $error("input not ready after load beat");

  // a sample blocks the input while it runs
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SAMPLE |=> !s_axis_tready)
    else $error("input ready straight after sample beat");

  // interpolated channels stay within range
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_W-1:0] <= OUT_MAX
      && m_axis_tdata[2*OUT_W-1:OUT_W] <= OUT_MAX
      && m_axis_tdata[3*OUT_W-1:2*OUT_W] <= OUT_MAX)
    else $error("result channel out of range");

endmodule

bind bilinear_image_resampler_unit bir_checker u_bir_checker (.*);
`default_nettype wire
